// File: rtl/smmc_pkg.sv
// Shared types and constants for the stepper motion mode controller.
package smmc_pkg;

  // Host op codes on the input channel
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_MOVE    = 3'd1;
  localparam logic [2:0] OP_SET_VEL = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_ENABLE  = 3'd4;
  localparam logic [2:0] OP_SET_POS = 3'd5;

  // Command queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Number of result slots per item
  localparam int unsigned N_SLOTS = 3;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_STOPPED  = 2'd1,
    MODE_MOVING   = 2'd2,
    MODE_VELOCITY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    GEN_NONE        = 3'd0,
    GEN_STOP        = 3'd1,
    GEN_START_COUNT = 3'd2,
    GEN_START_VEL   = 3'd3,
    GEN_SET_FREQ    = 3'd4
  } gen_t;

  // Classified item kinds
  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_MOVE,
    KIND_SET_VEL,
    KIND_STOP,
    KIND_ENABLE,
    KIND_SET_POS,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] rate;
    logic [31:0] emitted;
    logic        done;
  } item_t;

  typedef struct packed {
    gen_t        cmd;
    logic [31:0] count;
    logic [31:0] rate;
    logic        ccw;
  } res_t;

endpackage

// File: rtl/stepper_motion_mode_controller_core.sv
// Stepper motion mode controller: one channel of step/dir mode control, ticks and host commands.
// Each input item (a feedback tick or a host command) yields one to three results, one per
// generator command, and the result port moves one transfer per cycle while out_ready is high;
// a command or quiet tick yields one result, a tick that stops, starts and sets the frequency
// yields three. Items first pass a classifier and a two-entry queue, so input transfers
// continue while the results of an earlier item drain; the back end applies the next item in
// the same cycle as the final result of the previous one is transferred. The mode, position
// and at-target fields show the state after the item and repeat on each of its results;
// last marks the final one.
module stepper_motion_mode_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_operand_value,
  input  logic [31:0]        in_move_rate,
  input  logic [31:0]        in_pulses_emitted,
  input  logic               in_pulse_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_mode,
  output logic signed [31:0] out_position,
  output logic               out_at_target,
  output logic               out_accepted,
  output logic [2:0]         out_gen_cmd,
  output logic [31:0]        out_gen_count,
  output logic [31:0]        out_gen_rate,
  output logic               out_dir_ccw,
  output logic               out_last
);
  import smmc_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  smmc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_operand_value  (in_operand_value),
    .in_move_rate      (in_move_rate),
    .in_pulses_emitted (in_pulses_emitted),
    .in_pulse_done     (in_pulse_done),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item)
  );

  smmc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mode      (out_mode),
    .out_position  (out_position),
    .out_at_target (out_at_target),
    .out_accepted  (out_accepted),
    .out_gen_cmd   (out_gen_cmd),
    .out_gen_count (out_gen_count),
    .out_gen_rate  (out_gen_rate),
    .out_dir_ccw   (out_dir_ccw),
    .out_last      (out_last)
  );

endmodule

// File: rtl/smmc_front.sv
// Front end: classifies incoming items and queues them for the back end.
module smmc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic signed [31:0]  in_operand_value,
  input  logic [31:0]         in_move_rate,
  input  logic [31:0]         in_pulses_emitted,
  input  logic                in_pulse_done,
  output logic                q_valid,
  input  logic                q_ready,
  output smmc_pkg::item_t     q_item
);
  import smmc_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  item_t           cls;
  logic            push, pop;

  // Classify the op; a move with zero rate and unknown ops are rejected
  always_comb begin
    cls.value   = in_operand_value;
    cls.rate    = in_move_rate;
    cls.emitted = in_pulses_emitted;
    cls.done    = in_pulse_done;
    case (in_op)
      OP_TICK:    cls.kind = KIND_TICK;
      OP_MOVE:    cls.kind = (in_move_rate == 32'd0) ? KIND_REJECT : KIND_MOVE;
      OP_SET_VEL: cls.kind = KIND_SET_VEL;
      OP_STOP:    cls.kind = KIND_STOP;
      OP_ENABLE:  cls.kind = KIND_ENABLE;
      OP_SET_POS: cls.kind = KIND_SET_POS;
      default:    cls.kind = KIND_REJECT;
    endcase
  end

  assign in_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/smmc_back.sv
// Back end: applies items to the controller state and issues generator results.
module smmc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  smmc_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_mode,
  output logic signed [31:0]  out_position,
  output logic                out_at_target,
  output logic                out_accepted,
  output logic [2:0]          out_gen_cmd,
  output logic [31:0]         out_gen_count,
  output logic [31:0]         out_gen_rate,
  output logic                out_dir_ccw,
  output logic                out_last
);
  import smmc_pkg::*;

  // Controller state
  mode_t       mode_r, mode_nxt;
  logic [31:0] position_r, position_nxt;
  logic [31:0] baseline_r, baseline_nxt;
  logic        dir_cw_r, dir_cw_nxt;
  logic        move_done_r, move_done_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [31:0] srate_r, srate_nxt;
  logic [31:0] svel_r, svel_nxt;
  logic        sen_r, sen_nxt;
  logic        svmode_r, svmode_nxt;
  logic        stop_pend_r, stop_pend_nxt;
  logic        setpos_pend_r, setpos_pend_nxt;
  logic [31:0] setpos_val_r, setpos_val_nxt;

  // Result slots: exit stop, entry start, run command
  res_t              slot_r [N_SLOTS];
  res_t              slot_nxt [N_SLOTS];
  logic [N_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic              at_tgt_r, at_tgt_nxt;
  logic              acc_r, acc_nxt;

  logic        take, out_xfer, is_last;
  logic [31:0] pos0, base1, em, mag;
  mode_t       want;
  logic        md0, chg, dir1, started, vel_cw, tgt_gt, dn;
  res_t        sel;

  assign vel_cw = ~svel_r[31];
  assign mag    = vel_cw ? svel_r : (32'd0 - svel_r);

  // Result port: lowest valid slot goes first
  always_comb begin
    if (slot_vld_r[0]) begin
      sel = slot_r[0];
    end else if (slot_vld_r[1]) begin
      sel = slot_r[1];
    end else begin
      sel = slot_r[2];
    end
  end

  assign is_last  = (slot_vld_r == 3'b001) || (slot_vld_r == 3'b010) ||
                    (slot_vld_r == 3'b100);
  assign out_valid = (slot_vld_r != '0);
  assign out_xfer  = out_valid & out_ready;
  assign q_ready   = (slot_vld_r == '0) | (out_xfer & is_last);
  assign take      = q_valid & q_ready;

  assign out_mode      = mode_r;
  assign out_position  = position_r;
  assign out_at_target = at_tgt_r;
  assign out_accepted  = acc_r;
  assign out_gen_cmd   = sel.cmd;
  assign out_gen_count = sel.count;
  assign out_gen_rate  = sel.rate;
  assign out_dir_ccw   = sel.ccw;
  assign out_last      = is_last;

  // Pending requests and mode choice for a tick
  always_comb begin
    pos0 = setpos_pend_r ? setpos_val_r : position_r;
    md0  = stop_pend_r | move_done_r;
    case (mode_r)
      MODE_DISABLED: want = sen_r ? MODE_STOPPED : MODE_DISABLED;
      MODE_STOPPED: begin
        if (!sen_r) want = MODE_DISABLED;
        else if (svmode_r) want = MODE_VELOCITY;
        else if (tgt_r != pos0) want = MODE_MOVING;
        else want = MODE_STOPPED;
      end
      MODE_MOVING: begin
        if (!sen_r) want = MODE_DISABLED;
        else if (svmode_r) want = MODE_VELOCITY;
        else if (md0) want = MODE_STOPPED;
        else want = MODE_MOVING;
      end
      default: begin
        if (!sen_r) want = MODE_DISABLED;
        else if (!svmode_r) want = MODE_STOPPED;
        else want = MODE_VELOCITY;
      end
    endcase
    chg    = (want != mode_r);
    tgt_gt = ($signed(tgt_r) > $signed(pos0));
  end

  // Apply one item to the state and fill the result slots
  always_comb begin
    mode_nxt        = mode_r;
    position_nxt    = position_r;
    baseline_nxt    = baseline_r;
    dir_cw_nxt      = dir_cw_r;
    move_done_nxt   = move_done_r;
    tgt_nxt         = tgt_r;
    srate_nxt       = srate_r;
    svel_nxt        = svel_r;
    sen_nxt         = sen_r;
    svmode_nxt      = svmode_r;
    stop_pend_nxt   = stop_pend_r;
    setpos_pend_nxt = setpos_pend_r;
    setpos_val_nxt  = setpos_val_r;
    acc_nxt         = acc_r;
    base1           = baseline_r;
    dir1            = dir_cw_r;
    started         = 1'b0;
    em              = q_item.emitted;
    dn              = q_item.done;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    slot_vld_nxt = out_xfer ? (slot_vld_r & (slot_vld_r - 1'b1)) : slot_vld_r;

    if (take) begin
      acc_nxt      = 1'b1;
      slot_vld_nxt = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
        slot_nxt[i] = '{cmd: GEN_NONE, count: 32'd0, rate: 32'd0, ccw: ~dir_cw_r};
      end
      case (q_item.kind)
        KIND_TICK: begin
          setpos_pend_nxt = 1'b0;
          stop_pend_nxt   = 1'b0;
          move_done_nxt   = md0;
          position_nxt    = pos0;
          mode_nxt        = want;
          // exit action
          if (chg && (mode_r == MODE_MOVING || mode_r == MODE_VELOCITY)) begin
            slot_vld_nxt[0] = 1'b1;
            slot_nxt[0].cmd = GEN_STOP;
            if (mode_r == MODE_MOVING) begin
              move_done_nxt = 1'b1;
            end
          end
          // entry action
          if (chg && want == MODE_MOVING) begin
            move_done_nxt     = 1'b0;
            base1             = pos0;
            dir1              = tgt_gt;
            started           = 1'b1;
            slot_vld_nxt[1]   = 1'b1;
            slot_nxt[1].cmd   = GEN_START_COUNT;
            slot_nxt[1].count = tgt_gt ? (tgt_r - pos0) : (pos0 - tgt_r);
            slot_nxt[1].rate  = srate_r;
            slot_nxt[1].ccw   = ~tgt_gt;
          end else if (chg && want == MODE_VELOCITY) begin
            move_done_nxt    = 1'b0;
            base1            = pos0;
            dir1             = vel_cw;
            started          = 1'b1;
            slot_vld_nxt[1]  = 1'b1;
            slot_nxt[1].cmd  = GEN_START_VEL;
            slot_nxt[1].rate = mag;
            slot_nxt[1].ccw  = ~vel_cw;
          end
          // feedback counts as zero right after a start
          if (started) begin
            em = 32'd0;
            dn = 1'b0;
          end
          baseline_nxt = base1;
          dir_cw_nxt   = dir1;
          // run action
          if (want == MODE_MOVING) begin
            move_done_nxt = dn;
            position_nxt  = dir1 ? (base1 + em) : (base1 - em);
          end else if (want == MODE_VELOCITY) begin
            position_nxt     = dir1 ? (base1 + em) : (base1 - em);
            slot_vld_nxt[2]  = 1'b1;
            slot_nxt[2].rate = mag;
            if (vel_cw != dir1) begin
              dir_cw_nxt      = vel_cw;
              baseline_nxt    = dir1 ? (base1 + em) : (base1 - em);
              slot_nxt[2].cmd = GEN_START_VEL;
              slot_nxt[2].ccw = ~vel_cw;
            end else begin
              slot_nxt[2].cmd = GEN_SET_FREQ;
              slot_nxt[2].ccw = ~dir1;
            end
          end
          // no generator command: a single idle result
          if (slot_vld_nxt == '0) begin
            slot_vld_nxt[2] = 1'b1;
            slot_nxt[2].ccw = ~dir_cw_nxt;
          end
        end
        KIND_MOVE: begin
          tgt_nxt         = q_item.value;
          srate_nxt       = q_item.rate;
          svmode_nxt      = 1'b0;
          slot_vld_nxt[2] = 1'b1;
        end
        KIND_SET_VEL: begin
          svmode_nxt      = 1'b1;
          svel_nxt        = q_item.value;
          slot_vld_nxt[2] = 1'b1;
        end
        KIND_STOP: begin
          tgt_nxt         = position_r;
          svmode_nxt      = 1'b0;
          stop_pend_nxt   = 1'b1;
          slot_vld_nxt[2] = 1'b1;
        end
        KIND_ENABLE: begin
          sen_nxt         = q_item.value[0];
          slot_vld_nxt[2] = 1'b1;
        end
        KIND_SET_POS: begin
          setpos_pend_nxt = 1'b1;
          setpos_val_nxt  = q_item.value;
          slot_vld_nxt[2] = 1'b1;
        end
        default: begin
          acc_nxt         = 1'b0;
          slot_vld_nxt[2] = 1'b1;
        end
      endcase
    end
    at_tgt_nxt = (tgt_nxt == position_nxt);
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_DISABLED;
      position_r    <= '0;
      baseline_r    <= '0;
      dir_cw_r      <= 1'b0;
      move_done_r   <= 1'b0;
      tgt_r         <= '0;
      srate_r       <= '0;
      svel_r        <= '0;
      sen_r         <= 1'b0;
      svmode_r      <= 1'b0;
      stop_pend_r   <= 1'b0;
      setpos_pend_r <= 1'b0;
      setpos_val_r  <= '0;
      slot_vld_r    <= '0;
      at_tgt_r      <= 1'b0;
      acc_r         <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      position_r    <= position_nxt;
      baseline_r    <= baseline_nxt;
      dir_cw_r      <= dir_cw_nxt;
      move_done_r   <= move_done_nxt;
      tgt_r         <= tgt_nxt;
      srate_r       <= srate_nxt;
      svel_r        <= svel_nxt;
      sen_r         <= sen_nxt;
      svmode_r      <= svmode_nxt;
      stop_pend_r   <= stop_pend_nxt;
      setpos_pend_r <= setpos_pend_nxt;
      setpos_val_r  <= setpos_val_nxt;
      slot_vld_r    <= slot_vld_nxt;
      at_tgt_r      <= at_tgt_nxt;
      acc_r         <= acc_nxt;
    end
  end

  // Result slot payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule
